// ----- sv/encoder_speed_pi_loop_core_macros.svh -----
// Assertion macros for the checker file of the speed loop core
`ifndef ENCODER_SPEED_PI_LOOP_CORE_MACROS_SVH
`define ENCODER_SPEED_PI_LOOP_CORE_MACROS_SVH

// Check on every clock edge outside reset
`define ESPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset cycles included
`define ESPI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/espi_pkg.sv -----
// Types, constants and helper functions of the encoder speed PI loop core
package espi_pkg;

  localparam int unsigned POS_W      = 15;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOW_W     = 48;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned GAIN_SHIFT = 18;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [16:0] POS_MOD   = 17'd32768;
  localparam logic [16:0] WRAP_HIGH = 17'd32000;
  localparam logic [16:0] WRAP_LOW  = 17'd768;
  localparam logic signed [16:0] SPEED_SCALE = 17'sd56250;
  localparam logic signed [11:0] SLOW_GAIN   = 12'sd1638;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 31'd83886;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 31'd1678;
  localparam logic [GAIN_W-1:0] PROP_LIMIT_RST   = 31'd524288;
  localparam logic [GAIN_W-1:0] INTEG_LIMIT_RST  = 31'd524288;
  localparam logic [GAIN_W-1:0] OUTPUT_LIMIT_RST = 31'd524288;
  localparam logic [DIV_W-1:0]  UPDATE_DIV_RST   = 8'd2;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_PROP_LIMIT,
    REG_INTEG_LIMIT,
    REG_OUTPUT_LIMIT,
    REG_UPDATE_DIVIDER
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] prop_limit;
    logic [GAIN_W-1:0] integ_limit;
    logic [GAIN_W-1:0] output_limit;
    logic [DIV_W-1:0]  update_divider;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_FAST,
    ST_SLOW_MUL,
    ST_PROP_MUL,
    ST_INTEG_MUL,
    ST_INTEG,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic ld_in;
    logic calc_raw;
    logic calc_fast;
    logic calc_slow_mul;
    logic calc_prop_mul;
    logic calc_integ_mul;
    logic calc_integ;
    logic calc_sum;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic upd_due;
  } dp_sts_t;

  // Symmetric clamp to +-lim; the result always fits the data width
  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [47:0] v,
                                                         input logic [GAIN_W-1:0] lim);
    logic signed [47:0] l;
    logic signed [47:0] r;
    l = $signed({17'd0, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

// ----- sv/encoder_speed_pi_loop_core.sv -----
// Top level of the encoder speed estimator with PI speed controller
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tick: position, setpoint, restart
//  m_axis    out        m_axis_tvalid/tready       current, fast and slow speed, updated
//  apb       in         psel/penable/pwrite        six control registers, pready tied high
//
//  An update tick steps through raw, fast, slow_mul, prop_mul, integ_mul, integ, sum and out
//  (one step per datapath stage, the gain multiplier is shared by the P and I terms); a tick
//  without update goes from idle straight to the out step.
//  A new tick is taken once the sequencer is back in idle, also while the last result
//  still waits; a stalled sink holds the sequencer in its final step.
//  Reset (rst, synchronous) clears filters, integrator and tick counter, and sets the registers to their reset values.
module encoder_speed_pi_loop_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [14:0] encoder_pos, [46:15] target_speed, [47] zero
  input  logic [espi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] restart
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] current_cmd, [63:32] speed_fast, [95:64] speed_slow
  output logic [espi_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] updated
  output logic                                 m_axis_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [espi_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  espi_pkg::cfg_t    cfg;
  espi_pkg::dp_cmd_t cmd;
  espi_pkg::dp_sts_t sts;

  assign pready = 1'b1;

  espi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  espi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  espi_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_pos     (s_axis_tdata[14:0]),
    .in_target  ($signed(s_axis_tdata[46:15])),
    .in_restart (s_axis_tuser),
    .out_data   (m_axis_tdata),
    .out_upd    (m_axis_tuser)
  );

endmodule

// ----- sv/espi_cfg.sv -----
// Register file behind the APB-style configuration port
module espi_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [espi_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output espi_pkg::cfg_t               cfg
);

  espi_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = espi_pkg::reg_idx_t'(paddr[4:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= espi_pkg::PROP_GAIN_RST;
      cfg.integ_gain     <= espi_pkg::INTEG_GAIN_RST;
      cfg.prop_limit     <= espi_pkg::PROP_LIMIT_RST;
      cfg.integ_limit    <= espi_pkg::INTEG_LIMIT_RST;
      cfg.output_limit   <= espi_pkg::OUTPUT_LIMIT_RST;
      cfg.update_divider <= espi_pkg::UPDATE_DIV_RST;
    end else if (wr) begin
      case (idx)
        espi_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= pwdata[30:0];
        espi_pkg::REG_INTEG_GAIN:     cfg.integ_gain     <= pwdata[30:0];
        espi_pkg::REG_PROP_LIMIT:     cfg.prop_limit     <= pwdata[30:0];
        espi_pkg::REG_INTEG_LIMIT:    cfg.integ_limit    <= pwdata[30:0];
        espi_pkg::REG_OUTPUT_LIMIT:   cfg.output_limit   <= pwdata[30:0];
        espi_pkg::REG_UPDATE_DIVIDER: cfg.update_divider <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      espi_pkg::REG_PROP_GAIN:      prdata = {1'b0, cfg.prop_gain};
      espi_pkg::REG_INTEG_GAIN:     prdata = {1'b0, cfg.integ_gain};
      espi_pkg::REG_PROP_LIMIT:     prdata = {1'b0, cfg.prop_limit};
      espi_pkg::REG_INTEG_LIMIT:    prdata = {1'b0, cfg.integ_limit};
      espi_pkg::REG_OUTPUT_LIMIT:   prdata = {1'b0, cfg.output_limit};
      espi_pkg::REG_UPDATE_DIVIDER: prdata = {24'd0, cfg.update_divider};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/espi_ctrl.sv -----
// Sequencer for one tick: speed estimate, filters, PI terms, result word
module espi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  input  espi_pkg::dp_sts_t sts,
  output espi_pkg::dp_cmd_t cmd
);

  espi_pkg::state_t state, state_next;
  logic             out_valid, out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= espi_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      espi_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = sts.upd_due ? espi_pkg::ST_RAW : espi_pkg::ST_OUT;
        end
      end
      espi_pkg::ST_RAW:       state_next = espi_pkg::ST_FAST;
      espi_pkg::ST_FAST:      state_next = espi_pkg::ST_SLOW_MUL;
      espi_pkg::ST_SLOW_MUL:  state_next = espi_pkg::ST_PROP_MUL;
      espi_pkg::ST_PROP_MUL:  state_next = espi_pkg::ST_INTEG_MUL;
      espi_pkg::ST_INTEG_MUL: state_next = espi_pkg::ST_INTEG;
      espi_pkg::ST_INTEG:     state_next = espi_pkg::ST_SUM;
      espi_pkg::ST_SUM:       state_next = espi_pkg::ST_OUT;
      espi_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = espi_pkg::ST_IDLE;
        end
      end
      default: state_next = espi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    s_ready = 1'b0;
    case (state)
      espi_pkg::ST_IDLE: begin
        s_ready    = 1'b1;
        cmd.ld_in  = s_valid;
      end
      espi_pkg::ST_RAW:       cmd.calc_raw       = 1'b1;
      espi_pkg::ST_FAST:      cmd.calc_fast      = 1'b1;
      espi_pkg::ST_SLOW_MUL:  cmd.calc_slow_mul  = 1'b1;
      espi_pkg::ST_PROP_MUL:  cmd.calc_prop_mul  = 1'b1;
      espi_pkg::ST_INTEG_MUL: cmd.calc_integ_mul = 1'b1;
      espi_pkg::ST_INTEG:     cmd.calc_integ     = 1'b1;
      espi_pkg::ST_SUM:       cmd.calc_sum       = 1'b1;
      espi_pkg::ST_OUT:       cmd.ld_out         = out_free;
      default: ;
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    if (cmd.ld_out) begin
      out_valid_next = 1'b1;
    end else if (m_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_valid = out_valid;

endmodule

// ----- sv/espi_dp.sv -----
// Datapath: position difference, speed filters, shared gain multiplier, clamps
module espi_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  espi_pkg::cfg_t                     cfg,
  input  espi_pkg::dp_cmd_t                  cmd,
  output espi_pkg::dp_sts_t                  sts,
  input  logic [espi_pkg::POS_W-1:0]         in_pos,
  input  logic signed [espi_pkg::DATA_W-1:0] in_target,
  input  logic                               in_restart,
  output logic [espi_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_upd
);

  localparam int unsigned DW = espi_pkg::DATA_W;
  localparam int unsigned SW = espi_pkg::SLOW_W;
  localparam int unsigned GW = espi_pkg::GAIN_W;
  localparam int unsigned PW = DW + GW;
  localparam int unsigned MW = PW - espi_pkg::GAIN_SHIFT;

  // Tick state
  logic [espi_pkg::POS_W-1:0]  pos_r;
  logic signed [DW-1:0]        target_r;
  logic                        upd_r;
  logic [espi_pkg::POS_W-1:0]  prev_pos;
  logic                        prev_valid;
  logic [espi_pkg::DIV_W-1:0]  tick_count;
  logic [espi_pkg::DIV_W-1:0]  tick_inc;

  // Filters and controller state
  logic signed [DW-1:0]        fast;
  logic signed [SW-1:0]        slow;
  logic signed [DW-1:0]        integ;
  logic signed [DW-1:0]        held;

  // Intermediate registers
  logic signed [DW-1:0]        raw;
  logic signed [59:0]          sprod;
  logic [DW-1:0]               emag;
  logic                        eneg;
  logic [PW-1:0]               prod;
  logic signed [DW-1:0]        p_term;

  // Combinational terms
  logic [16:0]                 cur17, prev17;
  logic signed [16:0]          diff;
  logic signed [33:0]          raw_full;
  logic signed [32:0]          fdelta;
  logic signed [33:0]          fast_sum;
  logic signed [48:0]          sdelta;
  logic signed [59:0]          sprod_full;
  logic signed [32:0]          err, err_neg;
  logic [GW-1:0]               mul_b;
  logic [PW-1:0]               prod_full;
  logic signed [MW:0]          gmag, gval;

  assign tick_inc    = tick_count + 1'b1;
  assign sts.upd_due = tick_inc >= cfg.update_divider;

  always_comb begin
    cur17  = {2'b00, pos_r};
    prev17 = prev_valid ? {2'b00, prev_pos} : {2'b00, pos_r};
    if (prev17 > espi_pkg::WRAP_HIGH && cur17 < espi_pkg::WRAP_LOW) begin
      diff = $signed(espi_pkg::POS_MOD + cur17 - prev17);
    end else if (prev17 < espi_pkg::WRAP_LOW && cur17 > espi_pkg::WRAP_HIGH) begin
      diff = $signed(cur17 - espi_pkg::POS_MOD - prev17);
    end else begin
      diff = $signed(cur17 - prev17);
    end
    raw_full   = diff * espi_pkg::SPEED_SCALE;
    fdelta     = 33'(raw) - 33'(fast);
    fast_sum   = 34'(fast) + 34'(fdelta >>> 2);
    sdelta     = 49'($signed({fast, 16'h0000})) - 49'(slow);
    sprod_full = sdelta * espi_pkg::SLOW_GAIN;
    err        = 33'(target_r) - 33'(fast);
    err_neg    = -err;
    mul_b      = cmd.calc_integ_mul ? cfg.integ_gain : cfg.prop_gain;
    prod_full  = emag * mul_b;
    gmag       = $signed({1'b0, prod[PW-1:espi_pkg::GAIN_SHIFT]});
    gval       = eneg ? -gmag : gmag;
  end

  // Control state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos   <= '0;
      prev_valid <= 1'b0;
      tick_count <= '0;
      fast       <= '0;
      slow       <= '0;
      integ      <= '0;
      held       <= '0;
    end else begin
      if (cmd.ld_in) begin
        tick_count <= sts.upd_due ? '0 : tick_inc;
        if (in_restart) begin
          prev_valid <= 1'b0;
          slow       <= '0;
        end
      end
      if (cmd.calc_fast) begin
        fast       <= fast_sum[DW-1:0];
        prev_pos   <= pos_r;
        prev_valid <= 1'b1;
      end
      if (cmd.calc_prop_mul) begin
        slow <= slow + 48'($signed(sprod[59:16]));
      end
      if (cmd.calc_integ) begin
        integ <= espi_pkg::clamp_sym(48'(integ) + 48'(gval), cfg.integ_limit);
      end
      if (cmd.calc_sum) begin
        held <= espi_pkg::clamp_sym(48'(p_term) + 48'(integ), cfg.output_limit);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      pos_r    <= in_pos;
      target_r <= in_target;
      upd_r    <= sts.upd_due;
    end
    if (cmd.calc_raw) begin
      raw <= raw_full[DW-1:0];
    end
    if (cmd.calc_slow_mul) begin
      sprod <= sprod_full;
      eneg  <= err[32];
      emag  <= err[32] ? err_neg[DW-1:0] : err[DW-1:0];
    end
    if (cmd.calc_prop_mul || cmd.calc_integ_mul) begin
      prod <= prod_full;
    end
    if (cmd.calc_integ_mul) begin
      p_term <= espi_pkg::clamp_sym(48'(gval), cfg.prop_limit);
    end
    if (cmd.ld_out) begin
      out_data <= {slow[SW-1:16], fast, held};
      out_upd  <= upd_r;
    end
  end

endmodule

// ----- sv/espi_checker.sv -----
// Port-level checks of the speed loop core, bound to the top level
`include "encoder_speed_pi_loop_core_macros.svh"

module espi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [espi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  logic [63:0] last_hold;
  logic        m_take;

  assign m_take = m_axis_tvalid & m_axis_tready;

  // Track current command and fast speed of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_hold <= '0;
    end else if (m_take) begin
      last_hold <= m_axis_tdata[63:0];
    end
  end

  `ESPI_ASSERT(a_out_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
  `ESPI_ASSERT_ALWAYS(a_reset_no_out, rst |=> !m_axis_tvalid, "result word valid right after reset")
  `ESPI_ASSERT(a_one_tick_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second tick taken while one is in work")
  `ESPI_ASSERT(a_hold_between_updates, m_take && !m_axis_tuser |-> m_axis_tdata[63:0] == last_hold, "held outputs moved on a tick without update")

endmodule

bind encoder_speed_pi_loop_core espi_checker u_espi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/espi_loop_checker.sv -----
// Checker for the speed loop core: tracks register writes, predicts each result word, compares
module espi_loop_checker
  import espi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [14:0] encoder_pos, [46:15] target_speed, [47] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] restart
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] current_cmd, [63:32] speed_fast, [95:64] speed_slow
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] updated
  input  logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    errors,
  output int                    outstanding,
  output int                    updates
);

  localparam longint TURN_COUNTS = 32768;
  localparam longint WRAP_HI     = 32000;
  localparam longint WRAP_LO     = 768;
  localparam longint COUNT_SPEED = 56250;
  localparam longint SLOW_COEF   = 1638;
  localparam longint WORD_MAX    = 64'sd2147483647;
  localparam longint WORD_MIN    = -64'sd2147483648;
  localparam int     PRINT_MAX   = 40;

  typedef struct packed {
    logic [31:0] current_cmd;
    logic [31:0] speed_fast;
    logic [31:0] speed_slow;
    logic        updated;
  } loop_word_t;

  loop_word_t predicted_outputs[$];
  loop_word_t want_word;
  loop_word_t got_word;

  cfg_t             regs;
  logic [POS_W-1:0] last_pos;
  logic             last_pos_ok;
  logic [DIV_W-1:0] tick_cnt;
  longint           fast_spd;
  longint           slow_acc;
  longint           integ_acc;
  longint           held_cmd;

  initial begin
    errors = 0;
    outstanding = 0;
    updates = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= PRINT_MAX)
      $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
  endtask

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint clamp_to(longint v, logic [GAIN_W-1:0] lim);
    longint l;
    l = $signed({33'd0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // Magnitude times gain, shifted down, sign restored: truncates toward zero
  function automatic longint apply_gain(longint e, logic [GAIN_W-1:0] g);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = (e < 0) ? -e : e;
    prod = (mag * {33'd0, g}) >> GAIN_SHIFT;
    return (e < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic loop_word_t advance_speed_loop(logic [POS_W-1:0] pos,
                                                    logic signed [31:0] target,
                                                    logic restart);
    loop_word_t w;
    longint now_pos;
    longint old_pos;
    longint diff;
    longint raw;
    longint err;
    longint prop;
    longint slow_out;
    if (restart) begin
      last_pos_ok = 1'b0;
      slow_acc = 0;
    end
    tick_cnt = tick_cnt + 1'b1;
    w.updated = 1'b0;
    if (tick_cnt >= regs.update_divider) begin
      tick_cnt = '0;
      w.updated = 1'b1;
      if (!last_pos_ok) begin
        last_pos_ok = 1'b1;
        last_pos = pos;
      end
      now_pos = longint'(pos);
      old_pos = longint'(last_pos);
      // correct the difference across the 0/32768 seam
      if (old_pos > WRAP_HI && now_pos < WRAP_LO) begin
        diff = TURN_COUNTS + now_pos - old_pos;
      end else if (old_pos < WRAP_LO && now_pos > WRAP_HI) begin
        diff = now_pos - TURN_COUNTS - old_pos;
      end else begin
        diff = now_pos - old_pos;
      end
      last_pos = pos;
      raw = diff * COUNT_SPEED;
      fast_spd = sat_word(fast_spd + ((raw - fast_spd) >>> 2));
      slow_acc = slow_acc + ((((fast_spd <<< 16) - slow_acc) * SLOW_COEF) >>> 16);
      err = longint'(target) - fast_spd;
      prop = clamp_to(apply_gain(err, regs.prop_gain), regs.prop_limit);
      integ_acc = clamp_to(integ_acc + apply_gain(err, regs.integ_gain), regs.integ_limit);
      held_cmd = clamp_to(prop + integ_acc, regs.output_limit);
    end
    slow_out = sat_word(slow_acc >>> 16);
    w.current_cmd = held_cmd[31:0];
    w.speed_fast = fast_spd[31:0];
    w.speed_slow = slow_out[31:0];
    return w;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_PROP_GAIN:      return {1'b0, regs.prop_gain};
      REG_INTEG_GAIN:     return {1'b0, regs.integ_gain};
      REG_PROP_LIMIT:     return {1'b0, regs.prop_limit};
      REG_INTEG_LIMIT:    return {1'b0, regs.integ_limit};
      REG_OUTPUT_LIMIT:   return {1'b0, regs.output_limit};
      REG_UPDATE_DIVIDER: return {24'd0, regs.update_divider};
      default:            return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.prop_gain = 31'd83886;
      regs.integ_gain = 31'd1678;
      regs.prop_limit = 31'd524288;
      regs.integ_limit = 31'd524288;
      regs.output_limit = 31'd524288;
      regs.update_divider = 8'd2;
      last_pos = '0;
      last_pos_ok = 1'b0;
      tick_cnt = '0;
      fast_spd = 0;
      slow_acc = 0;
      integ_acc = 0;
      held_cmd = 0;
      predicted_outputs.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[4:2])
            REG_PROP_GAIN:      regs.prop_gain = pwdata[30:0];
            REG_INTEG_GAIN:     regs.integ_gain = pwdata[30:0];
            REG_PROP_LIMIT:     regs.prop_limit = pwdata[30:0];
            REG_INTEG_LIMIT:    regs.integ_limit = pwdata[30:0];
            REG_OUTPUT_LIMIT:   regs.output_limit = pwdata[30:0];
            REG_UPDATE_DIVIDER: regs.update_divider = pwdata[7:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[4:2])) begin
          report_mismatch($sformatf("register read at %0d", paddr), reg_value(paddr[4:2]),
                          prdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want_word = advance_speed_loop(s_axis_tdata[14:0], s_axis_tdata[46:15], s_axis_tuser);
        predicted_outputs.push_back(want_word);
        if (want_word.updated) updates++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, got_word.current_cmd);
        end else begin
          want_word = predicted_outputs.pop_front();
          if (got_word.current_cmd !== want_word.current_cmd)
            report_mismatch("current_cmd", want_word.current_cmd, got_word.current_cmd);
          if (got_word.speed_fast !== want_word.speed_fast)
            report_mismatch("speed_fast", want_word.speed_fast, got_word.speed_fast);
          if (got_word.speed_slow !== want_word.speed_slow)
            report_mismatch("speed_slow", want_word.speed_slow, got_word.speed_slow);
          if (got_word.updated !== want_word.updated)
            report_mismatch("updated", {31'd0, want_word.updated}, {31'd0, got_word.updated});
        end
      end
    end
    outstanding = predicted_outputs.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the speed loop core: clock, reset, tick stimulus, register set-up, verdict
module tb_top;
  import espi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [14:0] encoder_pos, [46:15] target_speed, [47] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] restart
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] current_cmd, [63:32] speed_fast, [95:64] speed_slow
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] updated
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int errors;
  int outstanding;
  int updates;
  int cycles = 0;
  int ticks_sent = 0;
  int restarts_sent = 0;
  int div_now = 2;

  logic [15:0]      stall_pattern = 16'hffff;
  int               stall_left = 0;
  int               stall_bit = 0;
  logic [POS_W-1:0] shaft_pos = '0;
  int               shaft_rate = 0;

  encoder_speed_pi_loop_core dut (.*);

  espi_loop_checker loop_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding", cycles, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sink readiness follows a 16-bit pattern, redrawn when its random hold count runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= 16'hffff;
        1:       stall_pattern <= 16'($urandom) | 16'($urandom);
        2:       stall_pattern <= 16'($urandom);
        default: stall_pattern <= 16'($urandom) & 16'($urandom);
      endcase
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_bit <= (stall_bit + 1) % 16;
    m_axis_tready <= stall_pattern[stall_bit];
  end

  // Enter and leave at a falling edge
  task automatic reg_access(reg_idx_t idx, logic wr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_reg(reg_idx_t idx, logic [31:0] value);
    reg_access(idx, 1'b1, value);
    reg_access(idx, 1'b0, '0);
  endtask

  // Spare upper bits of each write carry random values; the block drops them
  task automatic program_loop(logic [GAIN_W-1:0] pg, logic [GAIN_W-1:0] ig,
                              logic [GAIN_W-1:0] pl, logic [GAIN_W-1:0] il,
                              logic [GAIN_W-1:0] ol, logic [DIV_W-1:0] div);
    set_reg(REG_PROP_GAIN, {1'($urandom), pg});
    set_reg(REG_INTEG_GAIN, {1'($urandom), ig});
    set_reg(REG_PROP_LIMIT, {1'($urandom), pl});
    set_reg(REG_INTEG_LIMIT, {1'($urandom), il});
    set_reg(REG_OUTPUT_LIMIT, {1'($urandom), ol});
    set_reg(REG_UPDATE_DIVIDER, {24'($urandom), div});
    div_now = (div == 0) ? 1 : div;
  endtask

  // Present one tick and hold it until taken; returns at the next falling edge
  task automatic drive_tick(logic [POS_W-1:0] pos, logic [31:0] target, logic restart);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, target, pos};
    s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic int pick_rate();
    int m;
    case ($urandom_range(0, 3))
      0:       m = 50;
      1:       m = 700;
      2:       m = 3000;
      default: m = 16383;
    endcase
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1, 2:    return GAIN_W'($urandom_range(0, 1 << 20));
      3:       return GAIN_W'($urandom_range(0, 1 << 24));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_limit();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1, 2, 3: return GAIN_W'($urandom_range(0, 1 << 24));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Mostly a turning shaft with jitter; some noise positions, restarts and wild setpoints
  task automatic drive_motion(int count);
    int               burst_left;
    int               gap;
    int               pick;
    logic [POS_W-1:0] pos;
    logic [31:0]      target;
    logic             restart;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if ($urandom_range(0, 99) == 0) shaft_rate = pick_rate();
      shaft_pos = POS_W'(shaft_pos + shaft_rate);
      if ($urandom_range(0, 99) < 88) begin
        pos = POS_W'(shaft_pos + $urandom_range(0, 4) - 2);
      end else begin
        pos = POS_W'($urandom);
      end
      restart = ($urandom_range(0, 39) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        target = 32'(shaft_rate * 56250 * div_now) + 32'($urandom_range(0, 1 << 21))
                 - 32'(1 << 20);
      end else if (pick < 9) begin
        target = $urandom;
      end else begin
        target = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      end
      drive_tick(pos, target, restart);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [GAIN_W-1:0] pg;
    logic [GAIN_W-1:0] ig;
    logic [GAIN_W-1:0] pl;
    logic [GAIN_W-1:0] il;
    logic [GAIN_W-1:0] ol;
    logic [DIV_W-1:0]  div;
    int                count;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: hold ticks between updates, first sample after restart
    drive_tick(15'd100, 32'd0, 1'b1);
    drive_tick(15'd200, 32'd1000000, 1'b0);
    drive_tick(15'd300, 32'd1000000, 1'b0);
    drive_tick(15'd400, 32'hfff00000, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Update every tick: walk both sides of the wrap windows and setpoint extremes
    program_loop(31'd83886, 31'd1678, 31'd524288, 31'd524288, 31'd524288, 8'd1);
    drive_tick(15'd32767, 32'd0, 1'b1);
    drive_tick(15'd5, 32'd0, 1'b0);
    drive_tick(15'd32766, 32'd0, 1'b0);
    drive_tick(15'd0, 32'd0, 1'b0);
    drive_tick(15'd32000, 32'd0, 1'b0);
    drive_tick(15'd767, 32'd0, 1'b0);
    drive_tick(15'd32001, 32'd0, 1'b0);
    drive_tick(15'd768, 32'd0, 1'b0);
    drive_tick(15'd0, 32'h7fffffff, 1'b0);
    drive_tick(15'd0, 32'h80000000, 1'b0);
    drive_tick(15'd32767, 32'd0, 1'b0);
    drive_tick(15'd16384, 32'h55555555, 1'b1);
    drive_tick(15'd16384, 32'haaaaaaaa, 1'b0);
    drive_tick(15'd16500, 32'd0, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      pg = rand_gain();
      ig = rand_gain();
      pl = rand_limit();
      il = rand_limit();
      ol = rand_limit();
      div = DIV_W'($urandom_range(1, 4));
      count = 85;
      case (ph)
        0: begin
          pg = '1;
          ig = '1;
          pl = '1;
          il = '1;
          ol = '1;
          div = 8'd1;
        end
        1: begin
          pl = '0;
          il = '0;
          ol = '0;
        end
        2: begin
          pg = '0;
          ig = '0;
          div = 8'd0;
        end
        3: begin
          div = 8'd255;
          count = 30;
        end
        // lowered below the count left over from the slow phase
        4: div = 8'd3;
        default: ;
      endcase
      shaft_rate = pick_rate();
      program_loop(pg, ig, pl, il, ol, div);
      drive_motion(count);
      wait_drained();
    end

    $display("Drove %0d ticks (%0d with restart) over %0d register settings", ticks_sent,
             restarts_sent, PHASES + 2);
    $display("Checked %0d speed and PI updates, wrap crossings and hold ticks", updates);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
